// File: sv/fbfa_pkg.sv
// Shared types, sizes and helpers for the free block fit allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package fbfa_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int ADDR_BITS      = 16;
    localparam int SIZE_W         = 16;
    localparam int FIELD_ADDR_W   = 16;
    localparam int IDX_W          = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);
    localparam int CMP_W          = IDX_W + CNT_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PARTITIONS - 1);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_LIST  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Any policy code other than best or worst fit selects first fit.
    typedef logic [1:0] policy_t;
    localparam policy_t POL_BEST  = 2'd1;
    localparam policy_t POL_WORST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
    } entry_t;

    typedef struct packed {
        logic             shift;
        entry_t           tail;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
    } ring_ctl_t;

    function automatic logic [FIELD_ADDR_W-1:0] addr_to_field(input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS+FIELD_ADDR_W-1:0] tmp;
        tmp = {{FIELD_ADDR_W{1'b0}}, a};
        return tmp[FIELD_ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] field_to_addr(input logic [FIELD_ADDR_W-1:0] f);
        logic [ADDR_BITS+FIELD_ADDR_W-1:0] tmp;
        tmp = {{ADDR_BITS{1'b0}}, f};
        return tmp[ADDR_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/fbfa_cell.sv
// One partition cell of the rotating table: holds a start and a size.
// Depends on fbfa_pkg.
`default_nettype none

module fbfa_cell (
    input  wire               aclk,
    input  wire               shift,
    input  fbfa_pkg::entry_t  shift_in,
    input  wire               wr_en,
    input  fbfa_pkg::entry_t  wr_data,
    output fbfa_pkg::entry_t  q
);
    import fbfa_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (wr_en) begin
            entry_next = wr_data;
        end else if (shift) begin
            entry_next = shift_in;
        end
    end

    // Table contents are not reset; only entries below the fill count are read.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

// File: sv/fbfa_ctrl.sv
// Sequencer of the allocator: handshakes, fit policy, fill count and the
// two rotation passes over the cell ring. Depends on fbfa_pkg.
`default_nettype none

module fbfa_ctrl (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_we,
    input  wire [1:0]                           cfg_wdata,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire [1:0]                           s_cmd,
    input  wire [fbfa_pkg::FIELD_ADDR_W-1:0]    s_start_address,
    input  wire [fbfa_pkg::SIZE_W-1:0]          s_block_size,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [1:0]                          m_kind,
    output logic                                m_ok,
    output logic [fbfa_pkg::FIELD_ADDR_W-1:0]   m_address,
    output logic [fbfa_pkg::SIZE_W-1:0]         m_size_left,
    output logic                                m_last,
    input  fbfa_pkg::entry_t                    head,
    output fbfa_pkg::ring_ctl_t                 ring
);
    import fbfa_pkg::*;

    state_t                  state_reg, state_next;
    policy_t                 policy_reg, policy_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [SIZE_W-1:0]       req_reg, req_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        pick_reg, pick_next;
    logic [SIZE_W-1:0]       best_reg, best_next;
    logic                    res_ok_reg, res_ok_next;
    logic [FIELD_ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [SIZE_W-1:0]       res_size_reg, res_size_next;

    logic                    m_valid_reg, m_valid_next;
    cmd_t                    m_kind_reg, m_kind_next;
    logic                    m_ok_reg, m_ok_next;
    logic [FIELD_ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [SIZE_W-1:0]       m_size_reg, m_size_next;
    logic                    m_last_reg, m_last_next;

    logic              out_free;
    logic              in_range;
    logic              nonzero;
    logic              take;
    logic              idx_end;
    logic [IDX_W-1:0]  idx_inc;
    logic [SIZE_W-1:0] shrunk;

    assign out_free = !m_valid_reg || m_ready;
    assign in_range = CMP_W'(idx_reg) < CMP_W'(count_reg);
    assign nonzero  = in_range && (head.size != '0);
    assign idx_end  = (idx_reg == LAST_IDX);
    assign idx_inc  = idx_end ? '0 : idx_reg + IDX_W'(1);
    assign shrunk   = head.size - req_reg;

    // During the search pass: a list remembers the last nonzero entry, an
    // allocation keeps the candidate that the policy prefers so far.
    always_comb begin
        if (cmd_reg == CMD_LIST) begin
            take = nonzero;
        end else begin
            take = in_range && (head.size >= req_reg) &&
                   (!found_reg ||
                    (policy_reg == POL_BEST  && head.size < best_reg) ||
                    (policy_reg == POL_WORST && head.size > best_reg));
        end
    end

    always_comb begin
        state_next    = state_reg;
        policy_next   = policy_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        req_next      = req_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        res_ok_next   = res_ok_reg;
        res_addr_next = res_addr_reg;
        res_size_next = res_size_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_ok_next    = m_ok_reg;
        m_addr_next  = m_addr_reg;
        m_size_next  = m_size_reg;
        m_last_next  = m_last_reg;

        s_ready      = 1'b0;
        ring.shift   = 1'b0;
        ring.tail    = head;
        ring.wr_en   = 1'b0;
        ring.wr_idx  = count_reg[IDX_W-1:0];
        ring.wr_data = '{start: field_to_addr(s_start_address), size: s_block_size};

        if (cfg_we) begin
            policy_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = cmd_t'(s_cmd);
                    req_next   = s_block_size;
                    idx_next   = '0;
                    found_next = 1'b0;
                    unique case (cmd_t'(s_cmd))
                        CMD_LOAD: begin
                            if (count_reg < CNT_W'(MAX_PARTITIONS)) begin
                                ring.wr_en    = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                res_ok_next   = 1'b1;
                                res_addr_next = addr_to_field(field_to_addr(s_start_address));
                                res_size_next = s_block_size;
                            end else begin
                                res_ok_next   = 1'b0;
                                res_addr_next = '0;
                                res_size_next = '0;
                            end
                            state_next = ST_RESP;
                        end
                        CMD_CLEAR: begin
                            count_next    = '0;
                            res_ok_next   = 1'b1;
                            res_addr_next = '0;
                            res_size_next = '0;
                            state_next    = ST_RESP;
                        end
                        CMD_ALLOC, CMD_LIST: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                ring.shift = 1'b1;
                idx_next   = idx_inc;
                if (take) begin
                    found_next = 1'b1;
                    pick_next  = idx_reg;
                    best_next  = head.size;
                end
                if (idx_end) begin
                    if (found_reg || take) begin
                        state_next = ST_APPLY;
                    end else begin
                        res_ok_next   = 1'b0;
                        res_addr_next = '0;
                        res_size_next = '0;
                        state_next    = ST_RESP;
                    end
                end
            end

            ST_APPLY: begin
                if (cmd_reg == CMD_LIST) begin
                    // Hold the ring while the output register cannot take an entry.
                    if (!(nonzero && !out_free)) begin
                        ring.shift = 1'b1;
                        idx_next   = idx_inc;
                        if (nonzero) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = CMD_LIST;
                            m_ok_next    = 1'b1;
                            m_addr_next  = addr_to_field(head.start);
                            m_size_next  = head.size;
                            m_last_next  = (idx_reg == pick_reg);
                        end
                        if (idx_end) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    ring.shift = 1'b1;
                    idx_next   = idx_inc;
                    if (idx_reg == pick_reg) begin
                        ring.tail.start = head.start + field_to_addr(req_reg);
                        ring.tail.size  = shrunk;
                        res_ok_next     = 1'b1;
                        res_addr_next   = addr_to_field(head.start);
                        res_size_next   = shrunk;
                    end
                    if (idx_end) begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = cmd_reg;
                    m_ok_next    = res_ok_reg;
                    m_addr_next  = res_addr_reg;
                    m_size_next  = res_size_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            policy_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            policy_reg  <= policy_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        cmd_reg      <= cmd_next;
        req_reg      <= req_next;
        found_reg    <= found_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        res_size_reg <= res_size_next;
        m_kind_reg   <= m_kind_next;
        m_ok_reg     <= m_ok_next;
        m_addr_reg   <= m_addr_next;
        m_size_reg   <= m_size_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_ok        = m_ok_reg;
    assign m_address   = m_addr_reg;
    assign m_size_left = m_size_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

// File: sv/free_block_fit_allocator.sv
// Load and clear: the sequencer enters the response state, which registers the result
// once the output register is free. Allocate: one search rotation and one update rotation
// of the cell ring, then the response state. One item at a time for every command.
// List: one search rotation, then one result per cycle while the sink is ready.
// Synchronous active-low reset empties the table and selects first fit; cells are not reset.
`default_nettype none

module free_block_fit_allocator (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_we,
    input  wire [1:0]                           cfg_wdata,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire [1:0]                           s_cmd,
    input  wire [fbfa_pkg::FIELD_ADDR_W-1:0]    s_start_address,
    input  wire [fbfa_pkg::SIZE_W-1:0]          s_block_size,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [1:0]                          m_kind,
    output logic                                m_ok,
    output logic [fbfa_pkg::FIELD_ADDR_W-1:0]   m_address,
    output logic [fbfa_pkg::SIZE_W-1:0]         m_size_left,
    output logic                                m_last
);
    import fbfa_pkg::*;

    entry_t    cell_q [MAX_PARTITIONS];
    ring_ctl_t ring;

    fbfa_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_start_address (s_start_address),
        .s_block_size    (s_block_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_ok            (m_ok),
        .m_address       (m_address),
        .m_size_left     (m_size_left),
        .m_last          (m_last),
        .head            (cell_q[0]),
        .ring            (ring)
    );

    // The ring rotates towards cell 0; the sequencer feeds the tail cell.
    for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
        entry_t next_in;
        if (i == MAX_PARTITIONS - 1) begin : g_tail
            assign next_in = ring.tail;
        end else begin : g_body
            assign next_in = cell_q[i+1];
        end
        fbfa_cell u_cell (
            .aclk     (aclk),
            .shift    (ring.shift),
            .shift_in (next_in),
            .wr_en    (ring.wr_en && (ring.wr_idx == IDX_W'(i))),
            .wr_data  (ring.wr_data),
            .q        (cell_q[i])
        );
    end

    // Only one item is in flight: an accepted transaction closes the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is still being processed");

    // Loads, allocations and clears give a single result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != CMD_LIST) |-> m_last)
        else $error("single-result transaction without last");

    // Every failure result carries zero address and size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> (m_address == '0) && (m_size_left == '0) && m_last)
        else $error("failure result with nonzero payload");

    // The ring never rotates while a new entry is being loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ring.wr_en |-> !ring.shift && s_ready)
        else $error("load collides with ring rotation");

endmodule

`default_nettype wire
